// ----- hdl/arp_pkg.sv -----
`timescale 1ns / 1ps
package arp_pkg;

  localparam int CacheEntriesDef   = 16;
  localparam int WaitEntriesDef    = 16;
  localparam int RequestEntriesDef = 16;

  // commands
  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // frame kinds
  localparam logic [1:0] FRM_IPV4    = 2'd0;
  localparam logic [1:0] FRM_ARP_REQ = 2'd1;
  localparam logic [1:0] FRM_ARP_REP = 2'd2;

  // result kinds
  localparam logic [2:0] RES_IPV4    = 3'd0;
  localparam logic [2:0] RES_ARP_REQ = 3'd1;
  localparam logic [2:0] RES_ARP_REP = 3'd2;
  localparam logic [2:0] RES_DELIVER = 3'd3;
  localparam logic [2:0] RES_DROP    = 3'd4;

  // register indexes
  localparam logic [1:0] REG_OWN_IP   = 2'd0;
  localparam logic [1:0] REG_OWN_MAC  = 2'd1;
  localparam logic [1:0] REG_LIFETIME = 2'd2;
  localparam logic [1:0] REG_HOLDOFF  = 2'd3;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  // classified work for the back end
  typedef struct packed {
    logic [1:0]  op;
    logic        emit_deliver;
    logic        learn;
    logic        is_request;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] tag;
    logic [31:0] tip;
    logic [31:0] elapsed;
  } arp_job_t;

endpackage

// ----- hdl/arp_resolver_with_cache.sv -----
`timescale 1ns / 1ps
// ARP resolver with mapping cache. A command word is taken when start is high
// and busy is low; each result word appears for one cycle with done high and
// must be captured then, since the receiver cannot stall the block; last marks
// the final word of a command. A send walks the cache one entry per cycle; a
// miss also walks the request store and ends with an ARP request unless it is
// held off; a drop word goes out when the wait store is full. An ARP receive
// walks the cache, then the waiting datagrams when any wait, and may end with
// a reply; a rejected frame gives no word. A two-word queue sits in front of
// the sequencer, so busy rises only when it is full.
module arp_resolver_with_cache
  import arp_pkg::*;
#(
  parameter int CACHE_ENTRIES   = CacheEntriesDef,
  parameter int WAIT_ENTRIES    = WaitEntriesDef,
  parameter int REQUEST_ENTRIES = RequestEntriesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] next_hop_ip,
  input  logic [15:0] datagram_tag,
  input  logic [47:0] frame_dest_mac,
  input  logic [1:0]  frame_kind,
  input  logic        fcs_good,
  input  logic        carries_datagram,
  input  logic [31:0] arp_sender_ip,
  input  logic [47:0] arp_sender_mac,
  input  logic [31:0] arp_target_ip,
  input  logic [31:0] elapsed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        done,
  output logic [2:0]  result_kind,
  output logic [47:0] dest_mac,
  output logic [15:0] out_tag,
  output logic [31:0] resolve_ip,
  output logic        last
);

  logic [31:0] own_ip, cache_lifetime, request_holdoff;
  logic [47:0] own_mac;
  logic        job_valid, job_take;
  arp_job_t    job;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0; own_mac <= '0;
      cache_lifetime <= 32'd30000; request_holdoff <= 32'd5000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OWN_IP:   own_ip <= cfg_data[31:0];
        REG_OWN_MAC:  own_mac <= cfg_data;
        REG_LIFETIME: cache_lifetime <= cfg_data[31:0];
        REG_HOLDOFF:  request_holdoff <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  arp_front #(.QDepth(2)) u_front (
    .clk, .rst, .start, .busy, .command, .next_hop_ip, .datagram_tag,
    .frame_dest_mac, .frame_kind, .fcs_good, .carries_datagram,
    .arp_sender_ip, .arp_sender_mac, .arp_target_ip, .elapsed,
    .own_mac, .job_valid, .job, .job_take
  );

  arp_back #(
    .CacheEntries(CACHE_ENTRIES), .WaitEntries(WAIT_ENTRIES),
    .RequestEntries(REQUEST_ENTRIES)
  ) u_back (
    .clk, .rst, .job_valid, .job, .job_take, .own_ip, .cache_lifetime,
    .request_holdoff, .done, .result_kind, .dest_mac, .out_tag, .resolve_ip, .last
  );

`ifndef SYNTHESIS
  // a word is only taken from a non-empty queue
  a_take_not_empty: assert property (@(posedge clk) disable iff (rst)
    job_take |-> job_valid)
    else $error("queue read while empty");
  // a result word always carries a defined kind
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result_kind <= RES_DROP))
    else $error("bad result kind");
  // a drop word that is not last is followed by a request word
  a_drop_then_request: assert property (@(posedge clk) disable iff (rst)
    done && result_kind == RES_DROP && !last |=> done && result_kind == RES_ARP_REQ)
    else $error("drop not followed by request");
`endif

endmodule

// ----- hdl/arp_front.sv -----
`timescale 1ns / 1ps
module arp_front
  import arp_pkg::*;
#(
  parameter int QDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] next_hop_ip,
  input  logic [15:0] datagram_tag,
  input  logic [47:0] frame_dest_mac,
  input  logic [1:0]  frame_kind,
  input  logic        fcs_good,
  input  logic        carries_datagram,
  input  logic [31:0] arp_sender_ip,
  input  logic [47:0] arp_sender_mac,
  input  logic [31:0] arp_target_ip,
  input  logic [31:0] elapsed,
  input  logic [47:0] own_mac,
  output logic        job_valid,
  output arp_job_t    job,
  input  logic        job_take
);

  localparam int PW = (QDepth > 1) ? $clog2(QDepth) : 1;

  arp_job_t            q [QDepth];
  logic [PW-1:0]       wp, rp;
  logic [PW:0]         cnt;
  arp_job_t            cls;
  logic                addr_ok, push;

  // classify the incoming word
  always_comb begin
    addr_ok = ((frame_dest_mac == own_mac) || (frame_dest_mac == MAC_BCAST)) && fcs_good;
    cls = '0;
    cls.op      = command;
    cls.ip      = (command == CMD_SEND) ? next_hop_ip : arp_sender_ip;
    cls.mac     = arp_sender_mac;
    cls.tag     = datagram_tag;
    cls.tip     = arp_target_ip;
    cls.elapsed = elapsed;
    cls.emit_deliver = (command == CMD_RECV) && addr_ok && (frame_kind == FRM_IPV4)
                       && carries_datagram;
    cls.learn = (command == CMD_RECV) && addr_ok
                && ((frame_kind == FRM_ARP_REQ) || (frame_kind == FRM_ARP_REP));
    cls.is_request = (frame_kind == FRM_ARP_REQ);
  end

  assign busy      = (cnt == (PW+1)'(QDepth));
  assign push      = start && !busy;
  assign job_valid = (cnt != '0);
  assign job       = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cls;
  end

  // small FIFO toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(QDepth-1)) ? '0 : wp + 1'b1;
      if (job_take) rp <= (rp == PW'(QDepth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(job_take);
    end
  end

endmodule

// ----- hdl/arp_back.sv -----
`timescale 1ns / 1ps
module arp_back
  import arp_pkg::*;
#(
  parameter int CacheEntries   = CacheEntriesDef,
  parameter int WaitEntries    = WaitEntriesDef,
  parameter int RequestEntries = RequestEntriesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  arp_job_t    job,
  output logic        job_take,
  input  logic [31:0] own_ip,
  input  logic [31:0] cache_lifetime,
  input  logic [31:0] request_holdoff,
  output logic        done,
  output logic [2:0]  result_kind,
  output logic [47:0] dest_mac,
  output logic [15:0] out_tag,
  output logic [31:0] resolve_ip,
  output logic        last
);

  localparam int CW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int WW = (WaitEntries > 1) ? $clog2(WaitEntries) : 1;
  localparam int RW = (RequestEntries > 1) ? $clog2(RequestEntries) : 1;
  localparam int XW = ((CW > RW) ? ((CW > WW) ? CW : WW) : ((RW > WW) ? RW : WW)) + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CSCAN  = 4'd1;
  localparam logic [3:0] S_SEND   = 4'd2;
  localparam logic [3:0] S_RSCAN  = 4'd3;
  localparam logic [3:0] S_RDEC   = 4'd4;
  localparam logic [3:0] S_LEARN  = 4'd5;
  localparam logic [3:0] S_FLUSH  = 4'd6;
  localparam logic [3:0] S_REPLY  = 4'd7;
  localparam logic [3:0] S_TICK   = 4'd8;
  localparam logic [3:0] S_DELIV  = 4'd9;
  localparam logic [3:0] S_REQ    = 4'd10;
  localparam logic [3:0] S_FEND   = 4'd11;

  logic [3:0] state;

  // stores held in flops, walked one entry per cycle
  logic              c_valid [CacheEntries];
  logic [31:0]       c_ip    [CacheEntries];
  logic [47:0]       c_mac   [CacheEntries];
  logic [63:0]       c_exp   [CacheEntries];
  logic [31:0]       w_ip    [WaitEntries];
  logic [15:0]       w_tag   [WaitEntries];
  logic              r_valid [RequestEntries];
  logic [31:0]       r_ip    [RequestEntries];
  logic [63:0]       r_time  [RequestEntries];

  logic [63:0]       now_time;
  logic [WW:0]       wait_count, keep;
  arp_job_t          cur;
  logic [XW-1:0]     idx;

  // scan results
  logic              hit;
  logic [CW-1:0]     hit_slot;
  logic              same_f, free_f;
  logic [CW-1:0]     same_s, free_s, old_s;
  logic              rs_f, rf_f, ro_f;
  logic [RW-1:0]     rs_s, rf_s, ro_s;
  logic [47:0]       learned_mac;
  logic              pend_out;
  // flushed word held back until it is known whether it is the final one
  logic              h_f;
  logic [15:0]       h_tag;

  logic [CW-1:0]     ci;
  logic [RW-1:0]     ri;
  logic [WW-1:0]     wi;

  assign ci = idx[CW-1:0];
  assign ri = idx[RW-1:0];
  assign wi = idx[WW-1:0];
  assign job_take = (state == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      now_time <= '0;
      wait_count <= '0;
      done <= 1'b0;
      pend_out <= 1'b0;
      for (int i = 0; i < CacheEntries; i++) c_valid[i] <= 1'b0;
      for (int i = 0; i < RequestEntries; i++) r_valid[i] <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            idx <= '0;
            hit <= 1'b0; same_f <= 1'b0; free_f <= 1'b0; old_s <= '0;
            rs_f <= 1'b0; rf_f <= 1'b0; ro_f <= 1'b0;
            keep <= '0;
            pend_out <= 1'b0;
            h_f <= 1'b0;
            priority if (job.op == CMD_SEND) state <= S_CSCAN;
            else if (job.op == CMD_TICK) state <= S_TICK;
            else if (job.emit_deliver) state <= S_DELIV;
            else if (job.learn) state <= S_CSCAN;
            else state <= S_IDLE;
          end
        end
        S_DELIV: begin
          done <= 1'b1; result_kind <= RES_DELIVER; dest_mac <= '0;
          out_tag <= cur.tag; resolve_ip <= '0; last <= 1'b1;
          state <= S_IDLE;
        end
        S_TICK: begin
          now_time <= now_time + {32'd0, cur.elapsed};
          for (int i = 0; i < CacheEntries; i++)
            if (c_valid[i] && c_exp[i] <= now_time + {32'd0, cur.elapsed})
              c_valid[i] <= 1'b0;
          state <= S_IDLE;
        end
        // cache walk: live hit for send, match/free/oldest for learn
        S_CSCAN: begin
          if (c_valid[ci] && c_ip[ci] == cur.ip) begin
            if (!hit && c_exp[ci] > now_time) begin
              hit <= 1'b1; hit_slot <= ci;
            end
            if (!same_f) begin same_f <= 1'b1; same_s <= ci; end
          end
          if (!c_valid[ci] && !free_f) begin free_f <= 1'b1; free_s <= ci; end
          if (ci != '0 && c_exp[ci] < c_exp[old_s]) old_s <= ci;
          if (idx == XW'(CacheEntries-1)) begin
            idx <= '0;
            state <= (cur.op == CMD_SEND) ? S_SEND : S_LEARN;
          end else idx <= idx + 1'b1;
        end
        S_SEND: begin
          if (hit) begin
            done <= 1'b1; result_kind <= RES_IPV4; dest_mac <= c_mac[hit_slot];
            out_tag <= cur.tag; resolve_ip <= '0; last <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (wait_count < (WW+1)'(WaitEntries)) begin
              w_ip[wait_count[WW-1:0]]  <= cur.ip;
              w_tag[wait_count[WW-1:0]] <= cur.tag;
              wait_count <= wait_count + 1'b1;
            end else begin
              pend_out <= 1'b1;
              result_kind <= RES_DROP; dest_mac <= '0;
              out_tag <= cur.tag; resolve_ip <= '0;
            end
            state <= S_RSCAN;
          end
        end
        S_RSCAN: begin
          if (r_valid[ri]) begin
            if (!rs_f && r_ip[ri] == cur.ip) begin rs_f <= 1'b1; rs_s <= ri; end
            if (!ro_f || r_time[ri] < r_time[ro_s]) begin ro_f <= 1'b1; ro_s <= ri; end
          end else if (!rf_f) begin rf_f <= 1'b1; rf_s <= ri; end
          if (idx == XW'(RequestEntries-1)) state <= S_RDEC;
          else idx <= idx + 1'b1;
        end
        S_RDEC: begin
          if (rs_f && (now_time - r_time[rs_s]) < {32'd0, request_holdoff}) begin
            // held off: only a pending drop word goes out
            if (pend_out) begin done <= 1'b1; last <= 1'b1; end
            state <= S_IDLE;
          end else begin
            if (rs_f) begin
              r_valid[rs_s] <= 1'b1; r_ip[rs_s] <= cur.ip; r_time[rs_s] <= now_time;
            end else if (rf_f) begin
              r_valid[rf_s] <= 1'b1; r_ip[rf_s] <= cur.ip; r_time[rf_s] <= now_time;
            end else begin
              r_valid[ro_s] <= 1'b1; r_ip[ro_s] <= cur.ip; r_time[ro_s] <= now_time;
            end
            // drop word first, request next cycle
            if (pend_out) begin done <= 1'b1; last <= 1'b0; end
            state <= S_REQ;
          end
        end
        S_REQ: begin
          done <= 1'b1; result_kind <= RES_ARP_REQ; dest_mac <= MAC_BCAST;
          out_tag <= '0; resolve_ip <= cur.ip; last <= 1'b1;
          state <= S_IDLE;
        end
        S_LEARN: begin
          if (same_f) begin
            c_ip[same_s] <= cur.ip; c_mac[same_s] <= cur.mac;
            c_exp[same_s] <= now_time + {32'd0, cache_lifetime};
          end else if (free_f) begin
            c_valid[free_s] <= 1'b1; c_ip[free_s] <= cur.ip; c_mac[free_s] <= cur.mac;
            c_exp[free_s] <= now_time + {32'd0, cache_lifetime};
          end else begin
            c_ip[old_s] <= cur.ip; c_mac[old_s] <= cur.mac;
            c_exp[old_s] <= now_time + {32'd0, cache_lifetime};
          end
          learned_mac <= cur.mac;
          state <= (wait_count != '0) ? S_FLUSH
                 : ((cur.is_request && cur.tip == own_ip) ? S_REPLY : S_IDLE);
        end
        // one waiting entry per cycle, compacting survivors
        S_FLUSH: begin
          if (w_ip[wi] == cur.ip) begin
            if (h_f) begin
              done <= 1'b1; result_kind <= RES_IPV4; dest_mac <= learned_mac;
              out_tag <= h_tag; resolve_ip <= '0; last <= 1'b0;
            end
            h_f <= 1'b1;
            h_tag <= w_tag[wi];
          end else begin
            w_ip[keep[WW-1:0]] <= w_ip[wi];
            w_tag[keep[WW-1:0]] <= w_tag[wi];
            keep <= keep + 1'b1;
          end
          if (idx == XW'(wait_count - 1'b1)) begin
            wait_count <= (w_ip[wi] == cur.ip) ? keep : keep + 1'b1;
            state <= S_FEND;
          end else idx <= idx + 1'b1;
        end
        // final flushed word, last unless a reply follows
        S_FEND: begin
          if (h_f) begin
            done <= 1'b1; result_kind <= RES_IPV4; dest_mac <= learned_mac;
            out_tag <= h_tag; resolve_ip <= '0;
            last <= !(cur.is_request && cur.tip == own_ip);
          end
          state <= (cur.is_request && cur.tip == own_ip) ? S_REPLY : S_IDLE;
        end
        S_REPLY: begin
          done <= 1'b1; result_kind <= RES_ARP_REP; dest_mac <= cur.mac;
          out_tag <= '0; resolve_ip <= cur.ip; last <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
